FILE: hw/rtl/block_bitmap_allocator_macros.svh
// Assertion helpers for the block bitmap allocator.
// Every property samples on clk and is held off while arst_n is low.
`ifndef BLOCK_BITMAP_ALLOCATOR_MACROS_SVH
`define BLOCK_BITMAP_ALLOCATOR_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BBA_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BBA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hw/rtl/bba_pkg.sv
`default_nettype none

package bba_pkg;

	localparam int MAX_GROUPS       = 16;
	localparam int BITMAP_BYTES_MAX = 1024;
	localparam int GROUP_W          = $clog2(MAX_GROUPS);
	localparam int BYTE_W           = $clog2(BITMAP_BYTES_MAX);
	localparam int STORE_DEPTH      = MAX_GROUPS * BITMAP_BYTES_MAX;
	localparam int ADDR_W           = GROUP_W + BYTE_W;
	localparam int BLOCK_W          = 17;
	localparam int COUNT_W          = 14;
	localparam int BPG_W            = 14;
	localparam int NG_W             = 5;
	localparam int NB_W             = 11;
	localparam int BPG_MAX          = 8192;
	localparam int BPG_MIN          = 8;
	localparam logic [7:0] BYTE_FULL = 8'hFF;

	typedef enum logic [1:0] {
		OP_ALLOC     = 2'd0,
		OP_RELEASE   = 2'd1,
		OP_LOAD_BYTE = 2'd2,
		OP_LOAD_CNT  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		STAT_OK       = 2'd0,
		STAT_NO_SPACE = 2'd1,
		STAT_RANGE    = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		CFG_BPG    = 2'd0,
		CFG_GROUPS = 2'd1,
		CFG_BYTES  = 2'd2
	} cfg_idx_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_DIV,
		S_SCAN,
		S_RD,
		S_WR,
		S_OUT
	} state_t;

	// Position of the lowest clear bit of a byte that is not full.
	function automatic logic [2:0] lowest_zero(input logic [7:0] b);
		logic [2:0] k;
		k = 3'd0;
		for (int i = 7; i >= 0; i--) begin
			if (!b[i]) begin
				k = 3'(i);
			end
		end
		return k;
	endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/bba_ram.sv
`default_nettype none

module bba_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/block_bitmap_allocator.sv
// Block bitmap allocator, one request at a time.
// Load requests pass a write state, then the output state. Release: the group
// search subtracts one group size per cycle; if in range, the bitmap byte is
// then read and written. Allocate: the byte scan reads one bitmap byte per
// cycle from the bitmap memory. After reset the bitmap memory is cleared one
// byte per cycle with s_tready low.
`default_nettype none
`include "block_bitmap_allocator_macros.svh"

module block_bitmap_allocator
	import bba_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	// configuration
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [13:0] cfg_wdata,
	// requests
	input  wire logic        s_tvalid,
	output      logic        s_tready,
	// [16:0] block_number, [20:17] group_index, [30:21] byte_index,
	// [44:31] load_value, [47:45] zero
	input  wire logic [47:0] s_tdata,
	// [1:0] operation
	input  wire logic [1:0]  s_tuser,
	// results
	output      logic        m_tvalid,
	input  wire logic        m_tready,
	// [16:0] allocated_block, [18:17] status, [23:19] zero
	output      logic [23:0] m_tdata
);

	state_t st_q, st_d;

	logic [BPG_W-1:0]   cfg_bpg_q;
	logic [NG_W-1:0]    cfg_groups_q;
	logic [NB_W-1:0]    cfg_bytes_q;
	logic [BPG_W-1:0]   bpg;
	logic [BPG_W-1:0]   bpg_m;
	logic [NG_W-1:0]    ng;
	logic [NB_W-1:0]    nb;

	logic [ADDR_W-1:0]  clr_q;
	logic [MAX_GROUPS-1:0] nz_q;

	op_t                op_q;
	logic [BLOCK_W-1:0] blk_q;
	logic [BLOCK_W-1:0] rem_q;
	logic [COUNT_W-1:0] val_q;
	logic [GROUP_W-1:0] g_q;
	logic [BYTE_W-1:0]  b_q;
	logic [NB_W-1:0]    j_q;
	logic [BYTE_W-1:0]  j_s1;
	logic               v_s1;
	logic [BLOCK_W-1:0] res_blk_q;
	status_t            res_st_q;
	logic               m_tvalid_q;
	logic [BLOCK_W-1:0] m_blk_q;
	status_t            m_st_q;

	logic               accept;
	op_t                in_op;
	logic [BLOCK_W-1:0] in_blk;
	logic [GROUP_W-1:0] in_grp;
	logic [BYTE_W-1:0]  in_byte;
	logic [COUNT_W-1:0] in_val;

	logic               grp_found;
	logic [GROUP_W-1:0] grp_first;
	logic               hit;
	logic               last_miss;
	logic               rem_fits;
	logic               div_last;
	logic               byte_ok;
	logic               out_free;
	logic [2:0]         bit_k;
	logic [BLOCK_W:0]   alloc_sum;

	logic               bm_we, bm_re;
	logic [ADDR_W-1:0]  bm_waddr, bm_raddr;
	logic [7:0]         bm_wdata, bm_rdata;
	logic               cn_we, cn_re;
	logic [GROUP_W-1:0] cn_waddr, cn_raddr;
	logic [COUNT_W-1:0] cn_wdata, cn_rdata;

	bba_ram #(.WIDTH(8), .DEPTH(STORE_DEPTH)) u_bitmap (
		.clk   (clk),
		.we    (bm_we),
		.waddr (bm_waddr),
		.wdata (bm_wdata),
		.re    (bm_re),
		.raddr (bm_raddr),
		.rdata (bm_rdata)
	);

	bba_ram #(.WIDTH(COUNT_W), .DEPTH(MAX_GROUPS)) u_counts (
		.clk   (clk),
		.we    (cn_we),
		.waddr (cn_waddr),
		.wdata (cn_wdata),
		.re    (cn_re),
		.raddr (cn_raddr),
		.rdata (cn_rdata)
	);

	// Effective configuration: group size rounded down to whole bytes and clamped.
	always_comb begin
		bpg_m = {cfg_bpg_q[BPG_W-1:3], 3'b000};
		if (bpg_m < BPG_W'(BPG_MIN)) begin
			bpg = BPG_W'(BPG_MIN);
		end else if (bpg_m > BPG_W'(BPG_MAX)) begin
			bpg = BPG_W'(BPG_MAX);
		end else begin
			bpg = bpg_m;
		end
		ng = (cfg_groups_q > NG_W'(MAX_GROUPS)) ? NG_W'(MAX_GROUPS) : cfg_groups_q;
		nb = (cfg_bytes_q > NB_W'(BITMAP_BYTES_MAX)) ? NB_W'(BITMAP_BYTES_MAX) : cfg_bytes_q;
	end

	assign s_tready = (st_q == S_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign in_op    = op_t'(s_tuser);
	assign in_blk   = s_tdata[16:0];
	assign in_grp   = s_tdata[20:17];
	assign in_byte  = s_tdata[30:21];
	assign in_val   = s_tdata[44:31];

	// First group in use that still has free blocks.
	always_comb begin
		grp_found = 1'b0;
		grp_first = '0;
		for (int i = MAX_GROUPS - 1; i >= 0; i--) begin
			if (nz_q[i] && (NG_W'(i) < ng)) begin
				grp_found = 1'b1;
				grp_first = GROUP_W'(i);
			end
		end
	end

	assign hit       = v_s1 && (bm_rdata != BYTE_FULL);
	assign last_miss = v_s1 && !hit && ({1'b0, j_s1} == nb - NB_W'(1));
	assign rem_fits  = (rem_q < BLOCK_W'(bpg));
	assign div_last  = ({1'b0, g_q} == ng - NG_W'(1));
	assign byte_ok   = ({1'b0, rem_q[BYTE_W+2:3]} < nb);
	assign out_free  = !m_tvalid_q || m_tready;
	assign bit_k     = (op_q == OP_ALLOC) ? lowest_zero(bm_rdata) : blk_q[2:0];
	assign alloc_sum = (BLOCK_W+1)'(g_q) * (BLOCK_W+1)'(bpg)
		+ (BLOCK_W+1)'({b_q, 3'b000}) + (BLOCK_W+1)'(bit_k);

	// Next state
	always_comb begin
		st_d = st_q;
		unique case (st_q)
			S_CLEAR: begin
				if (clr_q == ADDR_W'(STORE_DEPTH - 1)) begin
					st_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (accept) begin
					unique case (in_op)
						OP_ALLOC:   st_d = (grp_found && nb != '0) ? S_SCAN : S_OUT;
						OP_RELEASE: st_d = (ng != '0 && nb != '0) ? S_DIV : S_OUT;
						OP_LOAD_BYTE, OP_LOAD_CNT: st_d = S_WR;
					endcase
				end
			end
			S_DIV: begin
				priority if (rem_fits) begin
					st_d = byte_ok ? S_RD : S_OUT;
				end else if (div_last) begin
					st_d = S_OUT;
				end
			end
			S_SCAN: begin
				priority if (hit) begin
					st_d = S_WR;
				end else if (last_miss) begin
					st_d = S_OUT;
				end
			end
			S_RD:  st_d = S_WR;
			S_WR:  st_d = S_OUT;
			S_OUT: begin
				if (out_free) begin
					st_d = S_IDLE;
				end
			end
			default: st_d = S_CLEAR;
		endcase
	end

	// Memory controls
	always_comb begin
		bm_we    = 1'b0;
		bm_waddr = {g_q, b_q};
		bm_wdata = bm_rdata;
		bm_re    = 1'b0;
		bm_raddr = {g_q, b_q};
		cn_we    = 1'b0;
		cn_waddr = g_q;
		cn_wdata = cn_rdata;
		cn_re    = 1'b0;
		cn_raddr = g_q;
		unique case (st_q)
			S_CLEAR: begin
				bm_we    = 1'b1;
				bm_waddr = clr_q;
				bm_wdata = '0;
				cn_we    = (clr_q < ADDR_W'(MAX_GROUPS));
				cn_waddr = clr_q[GROUP_W-1:0];
				cn_wdata = '0;
			end
			S_SCAN: begin
				bm_re    = (j_q < nb) && !hit;
				bm_raddr = {g_q, j_q[BYTE_W-1:0]};
				cn_re    = 1'b1;
			end
			S_RD: begin
				bm_re = 1'b1;
				cn_re = 1'b1;
			end
			S_WR: begin
				unique case (op_q)
					OP_ALLOC: begin
						bm_we    = 1'b1;
						bm_wdata = bm_rdata | (8'd1 << bit_k);
						cn_we    = 1'b1;
						cn_wdata = cn_rdata - COUNT_W'(1);
					end
					OP_RELEASE: begin
						bm_we    = 1'b1;
						bm_wdata = bm_rdata & ~(8'd1 << bit_k);
						cn_we    = 1'b1;
						cn_wdata = (cn_rdata < COUNT_W'(bpg)) ? cn_rdata + COUNT_W'(1)
							: cn_rdata;
					end
					OP_LOAD_BYTE: begin
						bm_we    = 1'b1;
						bm_wdata = val_q[7:0];
					end
					OP_LOAD_CNT: begin
						cn_we    = 1'b1;
						cn_wdata = val_q;
					end
				endcase
			end
			S_IDLE, S_DIV, S_OUT: begin
			end
			default: begin
			end
		endcase
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q         <= S_CLEAR;
			clr_q        <= '0;
			nz_q         <= '0;
			v_s1         <= 1'b0;
			m_tvalid_q   <= 1'b0;
			cfg_bpg_q    <= BPG_W'(BPG_MAX);
			cfg_groups_q <= NG_W'(MAX_GROUPS);
			cfg_bytes_q  <= NB_W'(BITMAP_BYTES_MAX);
		end else begin
			st_q <= st_d;
			if (st_q == S_CLEAR) begin
				clr_q <= clr_q + ADDR_W'(1);
			end
			if (cfg_we) begin
				unique case (cfg_idx_t'(cfg_index))
					CFG_BPG:    cfg_bpg_q    <= cfg_wdata;
					CFG_GROUPS: cfg_groups_q <= cfg_wdata[NG_W-1:0];
					CFG_BYTES:  cfg_bytes_q  <= cfg_wdata[NB_W-1:0];
					default: begin
					end
				endcase
			end
			v_s1 <= (st_q == S_SCAN) && bm_re;
			if (cn_we && st_q != S_CLEAR) begin
				nz_q[cn_waddr] <= (cn_wdata != '0);
			end
			if (st_q == S_OUT && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// Request and result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q      <= in_op;
			blk_q     <= in_blk;
			rem_q     <= in_blk;
			val_q     <= in_val;
			b_q       <= in_byte;
			j_q       <= '0;
			res_blk_q <= '0;
			res_st_q  <= STAT_OK;
			unique case (in_op)
				OP_ALLOC: begin
					g_q <= grp_first;
					if (!grp_found || nb == '0) begin
						res_st_q <= STAT_NO_SPACE;
					end
				end
				OP_RELEASE: begin
					g_q <= '0;
					if (ng == '0 || nb == '0) begin
						res_st_q <= STAT_RANGE;
					end
				end
				OP_LOAD_BYTE, OP_LOAD_CNT: g_q <= in_grp;
			endcase
		end
		if (st_q == S_DIV) begin
			priority if (rem_fits) begin
				b_q <= rem_q[BYTE_W+2:3];
				if (!byte_ok) begin
					res_st_q <= STAT_RANGE;
				end
			end else if (div_last) begin
				res_st_q <= STAT_RANGE;
			end else begin
				rem_q <= rem_q - BLOCK_W'(bpg);
				g_q   <= g_q + GROUP_W'(1);
			end
		end
		if (st_q == S_SCAN) begin
			if (bm_re) begin
				j_q <= j_q + NB_W'(1);
			end
			j_s1 <= j_q[BYTE_W-1:0];
			if (hit) begin
				b_q <= j_s1;
			end else if (last_miss) begin
				res_st_q <= STAT_NO_SPACE;
			end
		end
		if (st_q == S_WR && op_q == OP_ALLOC) begin
			res_blk_q <= alloc_sum[BLOCK_W-1:0];
		end
		if (st_q == S_OUT && out_free) begin
			m_blk_q <= res_blk_q;
			m_st_q  <= res_st_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {5'b0, m_st_q, m_blk_q};

	`BBA_ASSERT_NOW(a_no_request_while_clearing, st_q == S_CLEAR, !s_tready,
		"request taken during clearing pass")
	`BBA_ASSERT_NOW(a_alloc_sets_one_bit, st_q == S_WR && op_q == OP_ALLOC,
		$countones(bm_wdata ^ bm_rdata) == 1, "allocate changed other than one bit")
	`BBA_ASSERT_NOW(a_failure_has_zero_block, m_tvalid && m_tdata[18:17] != STAT_OK,
		m_tdata[16:0] == '0, "failed request returned a block")
	`BBA_ASSERT_NOW(a_group_search_bound, st_q == S_DIV, NG_W'(g_q) < ng,
		"group search ran past groups in use")
	`BBA_ASSERT_NEXT(a_alloc_group_has_space, accept && in_op == OP_ALLOC && grp_found,
		nz_q[g_q], "allocate chose a group with no free count")

endmodule

`default_nettype wire
